### design/client_session_table_unit_assert.svh
// assertion macros for the client session table checker
// no dependencies; included by the checker file
`ifndef CLIENT_SESSION_TABLE_UNIT_ASSERT_SVH
`define CLIENT_SESSION_TABLE_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define CST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/cst_pkg.sv
// shared types and constants for the client session table
// no dependencies; used by every module of the block
package cst_pkg;

  localparam int SESSION_COUNT = 8;
  localparam int IDX_W = (SESSION_COUNT > 1) ? $clog2(SESSION_COUNT) : 1;
  localparam int CLIENT_W = 32;
  localparam int NONCE_W = 64;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SESSION_COUNT - 1);

  typedef enum logic [1:0] {
    ACT_SET_AUTH    = 2'd0,
    ACT_REMOVE      = 2'd1,
    ACT_QUERY       = 2'd2,
    ACT_STORE_NONCE = 2'd3
  } action_t;

  typedef struct packed {
    action_t             action;
    logic [CLIENT_W-1:0] client_id;
    logic                auth_flag;
    logic [NONCE_W-1:0]  nonce_low;
    logic [NONCE_W-1:0]  nonce_high;
  } req_item_t;

  typedef struct packed {
    logic               found;
    logic               authenticated;
    logic               evicted;
    logic [NONCE_W-1:0] nonce_out_low;
    logic [NONCE_W-1:0] nonce_out_high;
  } rsp_item_t;

  // first-hit record built up by the scan
  typedef struct packed {
    logic             match_hit;
    logic [IDX_W-1:0] match_idx;
    logic             match_auth;
    logic             free_hit;
    logic [IDX_W-1:0] free_idx;
    logic             unauth_hit;
    logic [IDX_W-1:0] unauth_idx;
  } scan_result_t;

  // one write into the session table
  typedef struct packed {
    logic                idx_valid;
    logic [IDX_W-1:0]    idx;
    logic                client_en;
    logic [CLIENT_W-1:0] client;
    logic                auth_en;
    logic                auth;
    logic                nonce_en;
    logic [NONCE_W-1:0]  nonce_low;
    logic [NONCE_W-1:0]  nonce_high;
  } store_write_t;

endpackage

### design/cst_entry_store.sv
// session table storage: ids, auth flags and nonces in flip-flops
// depends on cst_pkg
module cst_entry_store (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [cst_pkg::IDX_W-1:0]    scan_idx,
  input  logic [cst_pkg::IDX_W-1:0]    nonce_idx,
  input  cst_pkg::store_write_t        wr,
  output logic [cst_pkg::CLIENT_W-1:0] scan_client,
  output logic                         scan_auth,
  output logic [cst_pkg::NONCE_W-1:0]  nonce_low,
  output logic [cst_pkg::NONCE_W-1:0]  nonce_high
);
  import cst_pkg::*;

  logic [CLIENT_W-1:0] entry_client     [SESSION_COUNT];
  logic                entry_auth       [SESSION_COUNT];
  logic [NONCE_W-1:0]  entry_nonce_low  [SESSION_COUNT];
  logic [NONCE_W-1:0]  entry_nonce_high [SESSION_COUNT];

  // single write port, whole table cleared on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SESSION_COUNT; i++) begin
        entry_client[i]     <= '0;
        entry_auth[i]       <= 1'b0;
        entry_nonce_low[i]  <= '0;
        entry_nonce_high[i] <= '0;
      end
    end else if (wr.idx_valid) begin
      if (wr.client_en) begin
        entry_client[wr.idx] <= wr.client;
      end
      if (wr.auth_en) begin
        entry_auth[wr.idx] <= wr.auth;
      end
      if (wr.nonce_en) begin
        entry_nonce_low[wr.idx]  <= wr.nonce_low;
        entry_nonce_high[wr.idx] <= wr.nonce_high;
      end
    end
  end

  // entry under the scan pointer feeds the compare unit
  assign scan_client = entry_client[scan_idx];
  assign scan_auth   = entry_auth[scan_idx];

  // nonce of the matched entry for queries
  assign nonce_low  = entry_nonce_low[nonce_idx];
  assign nonce_high = entry_nonce_high[nonce_idx];

endmodule

### design/cst_scan_unit.sv
// shared compare unit: checks one entry per cycle while step is high and keeps the first hits
// depends on cst_pkg
module cst_scan_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         step,
  input  logic [cst_pkg::IDX_W-1:0]    idx,
  input  logic [cst_pkg::CLIENT_W-1:0] key,
  input  logic [cst_pkg::CLIENT_W-1:0] entry_client,
  input  logic                         entry_auth,
  output cst_pkg::scan_result_t        result
);
  import cst_pkg::*;

  logic is_match;
  logic is_free;
  logic is_unauth;

  // the compare itself
  assign is_match  = (entry_client == key);
  assign is_free   = (entry_client == '0);
  assign is_unauth = !entry_auth;

  // lowest index wins: record only the first hit of each kind
  always_ff @(posedge clk) begin
    if (rst || start) begin
      result <= '0;
    end else if (step) begin
      if (!result.match_hit && is_match) begin
        result.match_hit  <= 1'b1;
        result.match_idx  <= idx;
        result.match_auth <= entry_auth;
      end
      if (!result.free_hit && is_free) begin
        result.free_hit <= 1'b1;
        result.free_idx <= idx;
      end
      if (!result.unauth_hit && is_unauth) begin
        result.unauth_hit <= 1'b1;
        result.unauth_idx <= idx;
      end
    end
  end

endmodule

### design/client_session_table_unit.sv
// client session table: an accepted item is walked by the single compare unit,
// which checks each entry in index order (ST_SCAN); an update step (ST_APPLY)
// then writes the table and registers the result; no new item is taken until
// the block is back in ST_IDLE; a waiting result does not block accept but
// holds the next update
// synchronous reset frees every entry, clears flags, nonces and password_set
module client_session_table_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  cst_pkg::req_item_t req_item,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output cst_pkg::rsp_item_t rsp_item,
  input  logic               cfg_write_en,
  input  logic               cfg_write_data
);
  import cst_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_APPLY = 3'b100
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] scan_idx;
  req_item_t        cur;
  logic             password_set;

  logic                req_take;
  logic                rsp_free;
  logic                apply_go;
  scan_result_t        scan;
  store_write_t        wr;
  rsp_item_t           rsp_next;
  logic [CLIENT_W-1:0] scan_client;
  logic                scan_auth;
  logic [NONCE_W-1:0]  rd_nonce_low;
  logic [NONCE_W-1:0]  rd_nonce_high;

  assign req_stall = (state != ST_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign apply_go  = (state == ST_APPLY) && rsp_free;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      password_set <= 1'b0;
    end else if (cfg_write_en) begin
      password_set <= cfg_write_data;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_take) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_idx == LAST_IDX) state_next = ST_APPLY;
      end
      ST_APPLY: begin
        if (rsp_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      scan_idx <= '0;
    end else begin
      state <= state_next;
      if (req_take) begin
        scan_idx <= '0;
      end else if (state == ST_SCAN && scan_idx != LAST_IDX) begin
        scan_idx <= scan_idx + 1'b1;
      end
    end
  end

  // item held for the whole walk
  always_ff @(posedge clk) begin
    if (req_take) begin
      cur <= req_item;
    end
  end

  cst_entry_store u_store (
    .clk         (clk),
    .rst         (rst),
    .scan_idx    (scan_idx),
    .nonce_idx   (scan.match_idx),
    .wr          (wr),
    .scan_client (scan_client),
    .scan_auth   (scan_auth),
    .nonce_low   (rd_nonce_low),
    .nonce_high  (rd_nonce_high)
  );

  cst_scan_unit u_scan (
    .clk          (clk),
    .rst          (rst),
    .start        (req_take),
    .step         (state == ST_SCAN),
    .idx          (scan_idx),
    .key          (cur.client_id),
    .entry_client (scan_client),
    .entry_auth   (scan_auth),
    .result       (scan)
  );

  // table update and result for the finished walk
  always_comb begin
    wr                      = '0;
    wr.client               = cur.client_id;
    wr.auth                 = cur.auth_flag;
    wr.nonce_low            = '0;
    wr.nonce_high           = '0;
    wr.idx                  = scan.match_idx;
    rsp_next                = '0;
    rsp_next.found          = scan.match_hit;
    unique case (cur.action)
      ACT_SET_AUTH: begin
        wr.idx_valid = apply_go;
        wr.auth_en   = 1'b1;
        if (!scan.match_hit) begin
          wr.client_en = 1'b1;
          wr.nonce_en  = 1'b1;
          if (scan.free_hit) begin
            wr.idx = scan.free_idx;
          end else begin
            wr.idx           = scan.unauth_hit ? scan.unauth_idx : '0;
            rsp_next.evicted = 1'b1;
          end
        end
      end
      ACT_REMOVE: begin
        wr.idx_valid = apply_go && scan.match_hit;
        wr.client_en = 1'b1;
        wr.client    = '0;
        wr.auth_en   = 1'b1;
        wr.auth      = 1'b0;
        wr.nonce_en  = 1'b1;
      end
      ACT_QUERY: begin
        if (scan.match_hit) begin
          rsp_next.nonce_out_low  = rd_nonce_low;
          rsp_next.nonce_out_high = rd_nonce_high;
        end
        rsp_next.authenticated = !password_set || (scan.match_hit && scan.match_auth);
      end
      ACT_STORE_NONCE: begin
        wr.idx_valid  = apply_go && scan.match_hit;
        wr.nonce_en   = 1'b1;
        wr.nonce_low  = cur.nonce_low;
        wr.nonce_high = cur.nonce_high;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (apply_go) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_go) begin
      rsp_item <= rsp_next;
    end
  end

endmodule

### design/cst_checker.sv
// port-level checks for the client session table, bound to the top level
// depends on cst_pkg and client_session_table_unit_assert.svh
`include "client_session_table_unit_assert.svh"

module cst_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_stall,
  input logic               rsp_valid,
  input logic               rsp_stall,
  input cst_pkg::rsp_item_t rsp_item
);
  import cst_pkg::*;

  logic req_accept;
  logic nonce_nonzero;

  assign req_accept    = req_valid && !req_stall;
  assign nonce_nonzero = (rsp_item.nonce_out_low != '0) || (rsp_item.nonce_out_high != '0);

  // a stalled result holds
  `CST_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall,
    rsp_valid && $stable(rsp_item), "stalled result changed")

  // busy right after taking an item
  `CST_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_accept,
    req_stall, "block ready right after accepting an item")

  // eviction only happens on a miss and reports nothing else
  `CST_ASSERT_NOW(a_evict_miss, clk, rst, rsp_valid && rsp_item.evicted,
    !rsp_item.found && !rsp_item.authenticated && !nonce_nonzero,
    "eviction reported with a match or query data")

  // a nonce is only returned for a found entry
  `CST_ASSERT_NOW(a_nonce_found, clk, rst, rsp_valid && nonce_nonzero,
    rsp_item.found, "nonce returned without a match")

endmodule

bind client_session_table_unit cst_checker u_cst_checker (.*);
